// File: src/lpks_pkg.sv
// Shared types and constants for the linear-probe key set.
// No dependencies; every other file imports this package.
`default_nettype none

package lpks_pkg;

   localparam int KEY_W      = 32;
   localparam int OP_W       = 2;
   localparam int ERR_W      = 2;
   localparam int COUNT_W    = 10;
   localparam int VB_W       = 6;
   localparam int LG_RAW_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

   localparam logic [VB_W-1:0]     VB_RESET = 6'd32;
   localparam logic [VB_W-1:0]     VB_MIN   = 6'd1;
   localparam logic [VB_W-1:0]     VB_MAX   = 6'd32;
   localparam logic [LG_RAW_W-1:0] LG_RESET = 4'd10;
   localparam logic [LG_RAW_W-1:0] LG_MIN   = 4'd2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE = 2'd0,
      ERR_WIDE = 2'd1,
      ERR_FULL = 2'd2,
      ERR_MARK = 2'd3
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_VALID_BITS = 1'd0,
      REG_LG_SIZE    = 1'd1
   } reg_index_type;

   // Next slot pointer selection.
   typedef enum logic [2:0] {
      PS_HOLD = 3'd0,
      PS_ZERO = 3'd1,
      PS_STEP = 3'd2,
      PS_NEXT = 3'd3,
      PS_HOME = 3'd4,
      PS_SCAN = 3'd5
   } ptr_sel_type;

   typedef struct packed {
      ptr_sel_type ptr_sel;
      logic        mem_we;
      logic        wr_key;
      logic        key_load_req;
      logic        key_load_rd;
      logic        scan_load;
      logic        sweep_start;
      logic        sweep_full;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        cnt_clear;
      logic        res_init;
      logic        res_changed;
      logic        res_err_set;
      err_type     res_err;
      logic        rsp_load;
   } lpks_cmd_type;

   typedef struct packed {
      logic cfg_write;
      logic key_is_mark;
      logic key_too_wide;
      logic rd_hit;
      logic rd_empty;
      logic rd_stop;
      logic table_full;
      logic sweep_done;
      logic rsp_free;
   } lpks_stat_type;

endpackage

`default_nettype wire

// File: src/lpks_if.sv
// Valid/ready channel interfaces for requests, responses and register writes.
// Depends on lpks_pkg for field widths.
`default_nettype none

interface lpks_req_if;
   import lpks_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [KEY_W-1:0]  item;
   modport source (output valid, output operation, output item, input ready);
   modport sink   (input valid, input operation, input item, output ready);
endinterface

interface lpks_rsp_if;
   import lpks_pkg::*;
   logic               valid;
   logic               ready;
   logic               changed;
   logic [ERR_W-1:0]   error;
   logic [COUNT_W-1:0] item_count;
   modport source (output valid, output changed, output error, output item_count,
                   input ready);
   modport sink   (input valid, input changed, input error, input item_count,
                   output ready);
endinterface

interface lpks_csr_if;
   import lpks_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/linear_probe_key_set.sv
// Insert/delete probe from the key's home slot until a hit or an empty slot is read;
//   a delete that hits also shifts the following keys back; clear sweeps 2^lg_size slots.
// Items are handled one at a time, limited by the single read port of the slot memory,
//   which visits one slot per cycle.
// Reset and any register write sweep all 2^MAX_LG_SLOTS slots (one per cycle) with req ready low.
// Depends on lpks_pkg, lpks_if, lpks_ctrl and lpks_dp.
`default_nettype none

module linear_probe_key_set #(
   parameter int MAX_LG_SLOTS = 10
) (
   input  wire        clock,
   input  wire        reset,
   lpks_req_if.sink   req_chan,
   lpks_rsp_if.source rsp_chan,
   lpks_csr_if.sink   csr_chan
);
   import lpks_pkg::*;

   lpks_cmd_type  cmd;
   lpks_stat_type stat;
   logic          ctrl_req_ready;

   // Register writes are always taken; the controller reacts by sweeping the store.
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = ctrl_req_ready;

   // Controller: walks probe, insert, delete/backshift and clear sequences.
   lpks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (ctrl_req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: slot memory, pointer, count, config and the response register.
   lpks_dp #(
      .MAX_LG_SLOTS (MAX_LG_SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_item       (req_chan.item),
      .csr_valid      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_changed    (rsp_chan.changed),
      .rsp_error      (rsp_chan.error),
      .rsp_item_count (rsp_chan.item_count)
   );

   // Never load a response over one still waiting for transfer.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response register overwritten");

   // A result that reports an error never reports a change.
   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.changed && (rsp_chan.error != ERR_NONE)))
      else $error("changed set together with an error");

   // Hold off requests while the store is being swept after reset.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("request taken during reset sweep");

   // A register write starts a sweep, so no request is taken in the next cycle.
   a_cfg_sweep: assert property (@(posedge clock)
      (csr_chan.valid && csr_chan.ready) |=> !req_chan.ready)
      else $error("request taken right after register write");

   // The slot memory never writes while a new key is being loaded.
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.key_load_req |-> !cmd.mem_we)
      else $error("memory write during request transfer");

endmodule

`default_nettype wire

// File: src/lpks_ctrl.sv
// Sequencer for the key set: probe, insert, delete with backshift, clear sweep.
// Depends on lpks_pkg; drives lpks_dp through the command struct.
`default_nettype none

module lpks_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire [lpks_pkg::OP_W-1:0] req_op,
   output logic                  req_ready,
   input  lpks_pkg::lpks_stat_type stat,
   output lpks_pkg::lpks_cmd_type  cmd
);
   import lpks_pkg::*;

   typedef enum logic [7:0] {
      ST_SWEEP   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_DECODE  = 8'b0000_0100,
      ST_PROBE   = 8'b0000_1000,
      ST_BS_READ = 8'b0001_0000,
      ST_BS_HOME = 8'b0010_0000,
      ST_BS_FIND = 8'b0100_0000,
      ST_RESP    = 8'b1000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic           sweep_resp_ff, sweep_resp_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      sweep_resp_in = sweep_resp_ff;
      cmd           = '0;
      req_ready     = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            cmd.mem_we  = 1'b1;
            cmd.ptr_sel = PS_STEP;
            if (stat.sweep_done) begin
               state_in      = sweep_resp_ff ? ST_RESP : ST_IDLE;
               sweep_resp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = !stat.cfg_write;
            if (req_valid && !stat.cfg_write) begin
               cmd.key_load_req = 1'b1;
               cmd.res_init     = 1'b1;
               op_in            = op_type'(req_op);
               state_in         = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               OP_CLEAR: begin
                  cmd.ptr_sel     = PS_ZERO;
                  cmd.sweep_start = 1'b1;
                  cmd.cnt_clear   = 1'b1;
                  sweep_resp_in   = 1'b1;
                  state_in        = ST_SWEEP;
               end
               OP_INSERT, OP_DELETE: begin
                  if (stat.key_is_mark) begin
                     cmd.res_err_set = 1'b1;
                     cmd.res_err     = ERR_MARK;
                     state_in        = ST_RESP;
                  end else if (stat.key_too_wide) begin
                     cmd.res_err_set = 1'b1;
                     cmd.res_err     = ERR_WIDE;
                     state_in        = ST_RESP;
                  end else begin
                     cmd.ptr_sel = PS_HOME;
                     state_in    = ST_PROBE;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_PROBE: begin
            if (!stat.rd_stop) begin
               cmd.ptr_sel = PS_NEXT;
            end else if (op_ff == OP_DELETE) begin
               if (stat.rd_hit) begin
                  cmd.mem_we      = 1'b1;
                  cmd.cnt_dec     = 1'b1;
                  cmd.res_changed = 1'b1;
                  cmd.ptr_sel     = PS_NEXT;
                  state_in        = ST_BS_READ;
               end else begin
                  state_in = ST_RESP;
               end
            end else begin
               if (stat.rd_hit) begin
                  state_in = ST_RESP;
               end else if (stat.table_full) begin
                  cmd.res_err_set = 1'b1;
                  cmd.res_err     = ERR_FULL;
                  state_in        = ST_RESP;
               end else begin
                  cmd.mem_we      = 1'b1;
                  cmd.wr_key      = 1'b1;
                  cmd.cnt_inc     = 1'b1;
                  cmd.res_changed = 1'b1;
                  state_in        = ST_RESP;
               end
            end
         end
         ST_BS_READ: begin
            if (stat.rd_empty) begin
               state_in = ST_RESP;
            end else begin
               cmd.mem_we      = 1'b1;
               cmd.key_load_rd = 1'b1;
               cmd.scan_load   = 1'b1;
               state_in        = ST_BS_HOME;
            end
         end
         ST_BS_HOME: begin
            cmd.ptr_sel = PS_HOME;
            state_in    = ST_BS_FIND;
         end
         ST_BS_FIND: begin
            if (stat.rd_stop) begin
               cmd.mem_we  = 1'b1;
               cmd.wr_key  = 1'b1;
               cmd.ptr_sel = PS_SCAN;
               state_in    = ST_BS_READ;
            end else begin
               cmd.ptr_sel = PS_NEXT;
            end
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A register write empties the whole store.
      if (stat.cfg_write) begin
         cmd.ptr_sel     = PS_ZERO;
         cmd.sweep_start = 1'b1;
         cmd.sweep_full  = 1'b1;
         cmd.cnt_clear   = 1'b1;
         state_in        = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         op_ff         <= OP_NOP;
         sweep_resp_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         sweep_resp_ff <= sweep_resp_in;
      end
   end

endmodule

`default_nettype wire

// File: src/lpks_dp.sv
// Datapath for the key set: slot memory, probe pointer, key count, registers, result.
// Depends on lpks_pkg; controlled by lpks_ctrl.
`default_nettype none

module lpks_dp #(
   parameter int MAX_LG_SLOTS = 10
) (
   input  wire                        clock,
   input  wire                        reset,
   input  lpks_pkg::lpks_cmd_type     cmd,
   output lpks_pkg::lpks_stat_type    stat,
   input  wire [lpks_pkg::KEY_W-1:0]  req_item,
   input  wire                        csr_valid,
   input  wire [lpks_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [lpks_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire                        rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_changed,
   output logic [lpks_pkg::ERR_W-1:0]   rsp_error,
   output logic [lpks_pkg::COUNT_W-1:0] rsp_item_count
);
   import lpks_pkg::*;

   localparam int AW    = MAX_LG_SLOTS;
   localparam int SLOTS = 1 << MAX_LG_SLOTS;
   localparam int LG_W  = $clog2(MAX_LG_SLOTS + 1);

   logic [KEY_W-1:0] slot_mem [SLOTS];

   logic [VB_W-1:0]     vb_raw_ff;
   logic [LG_RAW_W-1:0] lg_raw_ff;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       scan_ff;
   logic [KEY_W-1:0]    probe_key_ff;
   logic [KEY_W-1:0]    rd_data_ff;
   logic [AW-1:0]       count_ff;
   logic                sweep_full_ff;
   logic                res_changed_ff;
   err_type             res_err_ff;
   logic                rsp_valid_ff;
   logic                rsp_changed_ff;
   err_type             rsp_err_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [VB_W-1:0]  vb_eff;
   logic [LG_W-1:0]  lg_eff;
   logic [VB_W-1:0]  lg_wide;
   logic [AW:0]      mask_wide;
   logic [AW-1:0]    slot_mask;
   logic [KEY_W-1:0] home_wide;
   logic [AW-1:0]    home_slot;
   logic [AW-1:0]    sweep_limit;
   logic [KEY_W-1:0] wr_data;

   // Saturate register values into their working ranges.
   always_comb begin
      if (vb_raw_ff < VB_MIN) begin
         vb_eff = VB_MIN;
      end else if (vb_raw_ff > VB_MAX) begin
         vb_eff = VB_MAX;
      end else begin
         vb_eff = vb_raw_ff;
      end
      if (lg_raw_ff < LG_MIN) begin
         lg_eff = LG_W'(LG_MIN);
      end else if (int'(lg_raw_ff) > MAX_LG_SLOTS) begin
         lg_eff = LG_W'(MAX_LG_SLOTS);
      end else begin
         lg_eff = LG_W'(lg_raw_ff);
      end
   end

   assign lg_wide   = VB_W'(lg_eff);
   assign mask_wide = ((AW+1)'(1) << lg_eff) - (AW+1)'(1);
   assign slot_mask = mask_wide[AW-1:0];

   // Home slot: top lg bits of the key's valid bits, or the valid bits moved up.
   always_comb begin
      if (vb_eff >= lg_wide) begin
         home_wide = probe_key_ff >> (vb_eff - lg_wide);
      end else begin
         home_wide = probe_key_ff << (lg_wide - vb_eff);
      end
   end

   assign home_slot   = home_wide[AW-1:0] & slot_mask;
   assign sweep_limit = sweep_full_ff ? '1 : slot_mask;
   assign wr_data     = cmd.wr_key ? probe_key_ff : EMPTY_KEY;

   always_comb begin
      case (cmd.ptr_sel)
         PS_HOLD: ptr_in = ptr_ff;
         PS_ZERO: ptr_in = '0;
         PS_STEP: ptr_in = ptr_ff + AW'(1);
         PS_NEXT: ptr_in = (ptr_ff + AW'(1)) & slot_mask;
         PS_HOME: ptr_in = home_slot;
         PS_SCAN: ptr_in = (scan_ff + AW'(1)) & slot_mask;
         default: ptr_in = ptr_ff;
      endcase
   end

   // Slot memory: write at the current pointer, read at the next one.
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         slot_mem[ptr_ff] <= wr_data;
      end
      if (cmd.mem_we && (ptr_ff == ptr_in)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= slot_mem[ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_raw_ff     <= VB_RESET;
         lg_raw_ff     <= LG_RESET;
         ptr_ff        <= '0;
         count_ff      <= '0;
         sweep_full_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (reg_index_type'(csr_index))
               REG_VALID_BITS: vb_raw_ff <= csr_data[VB_W-1:0];
               REG_LG_SIZE:    lg_raw_ff <= csr_data[LG_RAW_W-1:0];
               default:        vb_raw_ff <= vb_raw_ff;
            endcase
         end
         ptr_ff <= ptr_in;
         if (cmd.sweep_start) begin
            sweep_full_ff <= cmd.sweep_full;
         end
         if (cmd.cnt_clear) begin
            count_ff <= '0;
         end else if (cmd.cnt_inc) begin
            count_ff <= count_ff + AW'(1);
         end else if (cmd.cnt_dec && (count_ff != '0)) begin
            count_ff <= count_ff - AW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load_req) begin
         probe_key_ff <= req_item;
      end else if (cmd.key_load_rd) begin
         probe_key_ff <= rd_data_ff;
      end
      if (cmd.scan_load) begin
         scan_ff <= ptr_ff;
      end
      if (cmd.res_init) begin
         res_changed_ff <= 1'b0;
         res_err_ff     <= ERR_NONE;
      end else begin
         if (cmd.res_changed) begin
            res_changed_ff <= 1'b1;
         end
         if (cmd.res_err_set) begin
            res_err_ff <= cmd.res_err;
         end
      end
      if (cmd.rsp_load) begin
         rsp_changed_ff <= res_changed_ff;
         rsp_err_ff     <= res_err_ff;
         rsp_count_ff   <= COUNT_W'(count_ff);
      end
   end

   always_comb begin
      stat.cfg_write    = csr_valid;
      stat.key_is_mark  = (probe_key_ff == EMPTY_KEY);
      stat.key_too_wide = ((probe_key_ff >> vb_eff) != '0);
      stat.rd_hit       = (rd_data_ff == probe_key_ff);
      stat.rd_empty     = (rd_data_ff == EMPTY_KEY);
      stat.rd_stop      = stat.rd_hit || stat.rd_empty;
      stat.table_full   = (count_ff >= slot_mask);
      stat.sweep_done   = (ptr_ff == sweep_limit);
      stat.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_changed    = rsp_changed_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_item_count = rsp_count_ff;

endmodule

`default_nettype wire
